>>> design/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types, constants and the button table of the gamepad serial port.
// ----------------------------------------------------------------------------
package gsp_pkg;

    localparam int NUM_PORTS_DEF = 4;
    localparam int MAX_PORTS     = 8;
    localparam int DATA_W        = 8;
    localparam int STATE_W       = 16;
    localparam int CMD_W         = 3;
    localparam int PORT_W        = 2;
    localparam int BUTTON_W      = 4;

    localparam logic [STATE_W-1:0] RELEASED_ALL = 16'hFFFF;
    localparam logic [STATE_W-1:0] LOAD_FILL    = 16'hF000;

    typedef enum logic [CMD_W-1:0] {
        CMD_BUTTON     = 3'd0,
        CMD_LATCH      = 3'd1,
        CMD_CLOCK      = 3'd2,
        CMD_CONNECT    = 3'd3,
        CMD_DISCONNECT = 3'd4
    } cmd_t;

    typedef struct packed {
        logic               load;
        logic               shift;
        logic               button;
        logic               pressed;
        logic [STATE_W-1:0] mask;
        logic               attach;
        logic               detach;
    } port_ctrl_t;

    function automatic logic [STATE_W-1:0] map_button(input logic [BUTTON_W-1:0] idx);
        logic [STATE_W-1:0] m;
        unique case (idx)
            4'd0:    m = 16'h0001;
            4'd1:    m = 16'h0100;
            4'd2:    m = 16'h0002;
            4'd3:    m = 16'h0200;
            4'd4:    m = 16'h0004;
            4'd6:    m = 16'h0008;
            4'd9:    m = 16'h0400;
            4'd10:   m = 16'h0800;
            4'd11:   m = 16'h0010;
            4'd12:   m = 16'h0020;
            4'd13:   m = 16'h0040;
            4'd14:   m = 16'h0080;
            default: m = 16'h0000;
        endcase
        return m;
    endfunction

endpackage

>>> design/gamepad_serial_port_latch_shift.sv
// ----------------------------------------------------------------------------
// gamepad_serial_port_latch_shift
// Bank of gamepad ports behind a shared latch/clock serial data byte.
// ----------------------------------------------------------------------------
// Path: an item enters the input register, then the state update loads
//   the data byte register and result valid; a result stall holds it.
// Throughput: one item per cycle while the result is not stalled.
// Reset: buttons released, shift registers zero, all ports empty,
//   latch low, data byte zero, both pipeline stages empty.
module gamepad_serial_port_latch_shift
    import gsp_pkg::*;
#(
    parameter int NUM_PORTS = NUM_PORTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [PORT_W-1:0]   port,
    input  logic [BUTTON_W-1:0] button,
    input  logic                pressed,
    input  logic                level,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [DATA_W-1:0]   data_out
);

    localparam logic [DATA_W-1:0] USED_MASK = DATA_W'(8'hFF << (DATA_W - NUM_PORTS));

    logic                stage_valid_reg;
    logic [CMD_W-1:0]    command_reg;
    logic [PORT_W-1:0]   port_reg;
    logic [BUTTON_W-1:0] button_reg;
    logic                pressed_reg;
    logic                level_reg;

    logic                result_valid_reg;
    logic [DATA_W-1:0]   data_byte_reg;
    logic [DATA_W-1:0]   data_byte_next;
    logic                latch_level_reg;
    logic                latch_level_next;

    logic                out_ready;
    logic                advance;
    logic                take;
    port_ctrl_t          ctrl;
    logic [NUM_PORTS-1:0] port_bit;
    logic [NUM_PORTS-1:0] port_sel;
    logic [DATA_W-1:0]   data_shift;

    assign out_ready    = !result_valid_reg || !result_stall;
    assign advance      = stage_valid_reg && out_ready;
    assign item_stall   = stage_valid_reg && !out_ready;
    assign take         = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign data_out     = data_byte_reg;

    always_comb
    begin
        ctrl             = '0;
        ctrl.mask        = map_button(button_reg);
        ctrl.pressed     = pressed_reg;
        latch_level_next = latch_level_reg;
        if (advance)
        begin
            unique case (command_reg)
                CMD_BUTTON:
                    ctrl.button = 1'b1;
                CMD_LATCH:
                begin
                    latch_level_next = level_reg;
                    ctrl.load        = level_reg;
                    ctrl.shift       = level_reg;
                end
                CMD_CLOCK:
                    ctrl.shift = level_reg && !latch_level_reg;
                CMD_CONNECT:
                    ctrl.attach = 1'b1;
                CMD_DISCONNECT:
                    ctrl.detach = 1'b1;
                default:
                    ctrl.button = 1'b0;
            endcase
        end
    end

    for (genvar i = 0; i < NUM_PORTS; i++)
    begin : g_port
        assign port_sel[i] = (int'(port_reg) == i);

        gsp_port u_port (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .sel     (port_sel[i]),
            .bit_out (port_bit[i])
        );
    end

    always_comb
    begin
        data_shift = '0;
        for (int i = 0; i < NUM_PORTS; i++)
            data_shift[DATA_W-1-i] = port_bit[i];
    end

    assign data_byte_next = ctrl.shift ? data_shift : data_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            latch_level_reg  <= 1'b0;
            data_byte_reg    <= '0;
        end
        else
        begin
            if (!item_stall)
                stage_valid_reg <= item_valid;
            if (out_ready)
                result_valid_reg <= stage_valid_reg;
            latch_level_reg <= latch_level_next;
            data_byte_reg   <= data_byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            command_reg <= command;
            port_reg    <= port;
            button_reg  <= button;
            pressed_reg <= pressed;
            level_reg   <= level;
        end
    end

    a_unused_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (data_byte_reg & ~USED_MASK) == '0)
        else $error("data bit set for a position with no port");

    a_hold_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(data_byte_reg) && $stable(latch_level_reg))
        else $error("state changed with no item advancing");

    a_clock_blocked_by_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && command_reg == CMD_CLOCK && latch_level_reg) |=> $stable(data_byte_reg))
        else $error("clock shifted while latch high");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("advanced item produced no result");

    a_stalled_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |=> stage_valid_reg)
        else $error("stalled item dropped from input stage");

endmodule

>>> design/gsp_port.sv
// ----------------------------------------------------------------------------
// gsp_port
// One controller port: button mask, presence flag and 16-bit shift register.
// ----------------------------------------------------------------------------
module gsp_port
    import gsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  port_ctrl_t ctrl,
    input  logic       sel,
    output logic       bit_out
);

    logic [STATE_W-1:0] button_reg;
    logic [STATE_W-1:0] button_next;
    logic [STATE_W-1:0] shift_reg;
    logic [STATE_W-1:0] shift_next;
    logic               present_reg;
    logic               present_next;
    logic [STATE_W-1:0] shift_src;

    assign shift_src = (ctrl.load && present_reg) ? (button_reg | LOAD_FILL) : shift_reg;
    assign bit_out   = present_reg ? shift_src[0] : 1'b1;

    always_comb
    begin
        button_next  = button_reg;
        shift_next   = shift_reg;
        present_next = present_reg;
        if (sel && (ctrl.attach || ctrl.detach))
        begin
            present_next = ctrl.attach;
            button_next  = RELEASED_ALL;
            shift_next   = '0;
        end
        else if (sel && ctrl.button && present_reg)
        begin
            if (ctrl.pressed)
                button_next = button_reg & ~ctrl.mask;
            else
                button_next = button_reg | ctrl.mask;
        end
        else if (ctrl.shift && present_reg)
        begin
            shift_next = shift_src >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_reg  <= RELEASED_ALL;
            shift_reg   <= '0;
            present_reg <= 1'b0;
        end
        else
        begin
            button_reg  <= button_next;
            shift_reg   <= shift_next;
            present_reg <= present_next;
        end
    end

endmodule

>>> bench/gamepad_serial_port_latch_shift_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_serial_port_latch_shift_test
// Self-checking bench for the gamepad serial port bank. A scoreboard class
// tracks button masks, shift registers, port presence and the latch line,
// predicts the data byte for every transfer, and compares each returned byte
// in order. Stimulus is a directed opening, then random frame reads, plug
// events, malformed sequences and noise, with random idling on both sides and
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module gamepad_serial_port_latch_shift_test;
    import gsp_pkg::*;

    localparam int PORTS       = NUM_PORTS_DEF;
    localparam int ITEM_TARGET = 1600;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 8;
    localparam logic [CMD_W-1:0] CMD_SPARE = '1;

    class pad_scoreboard;
        logic [STATE_W-1:0] button_bit [16];
        logic [STATE_W-1:0] masks [PORTS];
        logic [STATE_W-1:0] shifters [PORTS];
        bit                 attached [PORTS];
        bit                 latch_high;
        logic [DATA_W-1:0]  serial_byte;
        logic [DATA_W-1:0]  expected_bytes [$];
        int                 errors;
        int                 matched;

        function new();
            button_bit = '{16'h0001, 16'h0100, 16'h0002, 16'h0200,
                           16'h0004, 16'h0000, 16'h0008, 16'h0000,
                           16'h0000, 16'h0400, 16'h0800, 16'h0010,
                           16'h0020, 16'h0040, 16'h0080, 16'h0000};
            for (int i = 0; i < PORTS; i++)
            begin
                masks[i]    = RELEASED_ALL;
                shifters[i] = '0;
                attached[i] = 1'b0;
            end
            latch_high  = 1'b0;
            serial_byte = '0;
            errors      = 0;
            matched     = 0;
        endfunction

        function void shift_out();
            serial_byte = '0;
            for (int i = 0; i < PORTS && i < DATA_W; i++)
            begin
                if (attached[i])
                begin
                    serial_byte[DATA_W-1-i] = shifters[i][0];
                    shifters[i] = shifters[i] >> 1;
                end
                else
                    serial_byte[DATA_W-1-i] = 1'b1;
            end
        endfunction

        function void note_transfer(input logic [CMD_W-1:0] cmd, input logic [PORT_W-1:0] prt,
                                    input logic [BUTTON_W-1:0] btn, input bit prs,
                                    input bit lvl);
            case (cmd)
                CMD_BUTTON:
                    if (prt < PORTS && attached[prt])
                        masks[prt] = prs ? (masks[prt] & ~button_bit[btn])
                                         : (masks[prt] | button_bit[btn]);
                CMD_LATCH:
                begin
                    latch_high = lvl;
                    if (lvl)
                    begin
                        for (int i = 0; i < PORTS; i++)
                            if (attached[i])
                                shifters[i] = masks[i] | LOAD_FILL;
                        shift_out();
                    end
                end
                CMD_CLOCK:
                    if (lvl && !latch_high)
                        shift_out();
                CMD_CONNECT, CMD_DISCONNECT:
                    if (prt < PORTS)
                    begin
                        attached[prt] = (cmd == CMD_CONNECT);
                        masks[prt]    = RELEASED_ALL;
                        shifters[prt] = '0;
                    end
                default: ;
            endcase
            expected_bytes.push_back(serial_byte);
        endfunction

        task report(input string msg);
            $display("%0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_byte(input logic [DATA_W-1:0] data);
            logic [DATA_W-1:0] want;
            if (expected_bytes.size() == 0)
                report($sformatf("data_out %02h arrived with no transfer pending", data));
            else
            begin
                want = expected_bytes.pop_front();
                if (data !== want)
                    report($sformatf("data_out %02h, expected %02h", data, want));
                else
                    matched++;
            end
        endtask
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    logic [CMD_W-1:0]    command      = '0;
    logic [PORT_W-1:0]   port         = '0;
    logic [BUTTON_W-1:0] button       = '0;
    logic                pressed      = 1'b0;
    logic                level        = 1'b0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [DATA_W-1:0]   data_out;

    pad_scoreboard board;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;
    int items_sent   = 0;
    int frames       = 0;
    int plug_events  = 0;
    int idle_cycles  = 0;

    gamepad_serial_port_latch_shift dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .port         (port),
        .button       (button),
        .pressed      (pressed),
        .level        (level),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .data_out     (data_out)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("No transfer for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [PORT_W-1:0] rand_port();
        return PORT_W'($urandom_range(0, 2**PORT_W - 1));
    endfunction

    function automatic logic [BUTTON_W-1:0] rand_button();
        return BUTTON_W'($urandom_range(0, 2**BUTTON_W - 1));
    endfunction

    function automatic bit rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PORT_W-1:0] prt,
                             input logic [BUTTON_W-1:0] btn, input bit prs, input bit lvl);
        int gap;
        item_valid <= 1'b1;
        command    <= cmd;
        port       <= prt;
        button     <= btn;
        pressed    <= prs;
        level      <= lvl;
        do
            @(posedge clk);
        while (item_stall);
        board.note_transfer(cmd, prt, btn, prs, lvl);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic press_some();
        int n;
        n = $urandom_range(0, 6);
        repeat (n)
            send_item(CMD_BUTTON, rand_port(), rand_button(), rand_bit(), rand_bit());
    endtask

    task automatic read_frame();
        int pulses;
        pulses = $urandom_range(8, 17);
        send_item(CMD_LATCH, rand_port(), rand_button(), rand_bit(), 1'b1);
        send_item(CMD_LATCH, rand_port(), rand_button(), rand_bit(), 1'b0);
        repeat (pulses)
        begin
            send_item(CMD_CLOCK, rand_port(), rand_button(), rand_bit(), 1'b1);
            send_item(CMD_CLOCK, rand_port(), rand_button(), rand_bit(), 1'b0);
        end
        frames++;
    endtask

    task automatic plug_mix();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            send_item(($urandom_range(0, 9) < 7) ? CMD_CONNECT : CMD_DISCONNECT,
                      rand_port(), rand_button(), rand_bit(), rand_bit());
            plug_events++;
        end
    endtask

    task automatic broken_frame();
        int n;
        logic [CMD_W-1:0] cmd;
        bit lvl;
        n = $urandom_range(2, 6);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0: begin cmd = CMD_LATCH; lvl = rand_bit(); end
                1: begin cmd = CMD_CLOCK; lvl = 1'b1; end
                2: begin cmd = CMD_CLOCK; lvl = 1'b0; end
                default: begin cmd = CMD_BUTTON; lvl = rand_bit(); end
            endcase
            send_item(cmd, rand_port(), rand_button(), rand_bit(), lvl);
        end
    endtask

    task automatic noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            send_item(CMD_W'($urandom_range(0, 2**CMD_W - 1)), rand_port(),
                      rand_button(), rand_bit(), rand_bit());
    endtask

    initial
    begin : receiver
        int stall_left;
        int r;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                board.check_byte(data_out);
            if (stall_left == 0)
            begin
                if (hold_request && !hold_done)
                begin
                    stall_left = HOLD_CYCLES;
                    hold_done  = 1'b1;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (!calm && r >= 65)
                        stall_left = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                end
            end
            result_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin : stimulus
        int pick;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty bank: shift and latch both read ones for every port
        send_item(CMD_CLOCK, 0, 0, 1'b0, 1'b1);
        send_item(CMD_LATCH, 3, 15, 1'b1, 1'b1);
        send_item(CMD_LATCH, 0, 0, 1'b0, 1'b0);
        send_item(CMD_BUTTON, 0, 0, 1'b1, 1'b0);
        for (int p = 0; p < PORTS; p++)
            send_item(CMD_CONNECT, PORT_W'(p), 0, 1'b0, 1'b0);
        send_item(CMD_BUTTON, 0, 0, 1'b1, 1'b0);
        send_item(CMD_BUTTON, 1, 14, 1'b1, 1'b1);
        send_item(CMD_BUTTON, 2, 15, 1'b1, 1'b0);
        send_item(CMD_BUTTON, 3, 5, 1'b1, 1'b0);
        send_item(CMD_BUTTON, 3, 10, 1'b1, 1'b0);
        send_item(CMD_BUTTON, 1, 14, 1'b0, 1'b0);
        send_item(CMD_SPARE, 3, 15, 1'b1, 1'b1);
        send_item(CMD_LATCH, 0, 0, 1'b0, 1'b1);
        send_item(CMD_CLOCK, 0, 0, 1'b0, 1'b1);
        send_item(CMD_LATCH, 0, 0, 1'b0, 1'b0);
        send_item(CMD_CLOCK, 0, 0, 1'b0, 1'b0);
        send_item(CMD_CLOCK, 0, 0, 1'b0, 1'b1);
        send_item(CMD_DISCONNECT, 2, 0, 1'b0, 1'b0);
        send_item(CMD_CLOCK, 0, 0, 1'b0, 1'b1);
        send_item(CMD_CONNECT, 0, 0, 1'b0, 1'b0);
        send_item(CMD_BUTTON, 2, 1, 1'b1, 1'b0);
        send_item(CMD_CLOCK, 0, 0, 1'b0, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 7) == 0);
            if (!hold_done && items_sent > ITEM_TARGET / 2)
            begin
                hold_request = 1'b1;
                calm         = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                press_some();
                read_frame();
            end
            else if (pick < 8)
                plug_mix();
            else if (pick == 8)
                noise();
            else
                broken_frame();
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        while (board.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d transfers: %0d frame reads, %0d plug events, one long hold-off.",
                 items_sent, frames, plug_events);
        $display("Data bytes matched: %0d, mismatches: %0d.", board.matched, board.errors);
        if (board.errors == 0 && board.expected_bytes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
